@@ design/mpsm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Motion pattern matcher package
// Payload types, request and register codes, and the sequencer states shared
// by the motion pattern similarity matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

    // Default number of stored patterns.
    localparam int MPSM_TABLE_DEPTH = 32;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_CHECK  = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    // Spare code; the block answers it without touching the table.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam int          CFG_INDEX_W         = 2;
    localparam logic [1:0]  CFG_MATCH_THRESHOLD = 2'd0;
    localparam logic [1:0]  CFG_MIN_NORM        = 2'd1;

    // Register reset values.
    localparam logic [15:0] THRESHOLD_RESET = 16'd29491;
    localparam logic [15:0] MIN_NORM_RESET  = 16'd1;

    // Q1.15 value of one, used to clamp the cosine.
    localparam logic [16:0] Q_ONE = 17'd32768;

    // Square root: sixteen result bits, two radicand bits a step.
    localparam logic [3:0]  SQRT_LAST = 4'd15;
    localparam logic [31:0] SQRT_TOP  = 32'h4000_0000;

    // Divider: seventeen quotient bits.
    localparam logic [4:0]  DIV_LAST = 5'd16;

    // Vector component selector.
    localparam logic [1:0]  COMP_X = 2'd0;
    localparam logic [1:0]  COMP_Y = 2'd1;
    localparam logic [1:0]  COMP_Z = 2'd2;

    // One request item.
    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } mpsm_in_t;

    // One result item.
    typedef struct packed {
        logic       is_match;
        logic [5:0] stored_count;
        logic       status;
    } mpsm_out_t;

    // One stored pattern with its precomputed norms.
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic [15:0]        accel_norm;
        logic [15:0]        gyro_norm;
    } mpsm_entry_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT,
        ST_WRITE,
        ST_READ,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_NPROD_MUL,
        ST_DIV_SETUP,
        ST_DIV,
        ST_SCORE,
        ST_DONE
    } mpsm_state_t;

endpackage : mpsm_pkg
`default_nettype wire

@@ design/motion_pattern_similarity_matcher_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Motion pattern similarity matcher
// Stores accelerometer and gyro patterns and scores a request pattern against
// them with a weighted cosine similarity, one multiplier shared under a small
// sequencer, and separate shift-subtract square root and divide steps.
// ----------------------------------------------------------------------------
// The block takes one item at a time and drops s_ready until that item's
// result is loaded into the output register. A clear, a rejected add, an
// unused code or a check on an empty table goes straight to the output
// register; an add first runs the 16-step square root once for each input
// vector. A check does the same for its input and then scores the stored
// patterns in order until the first match or the last stored pattern: per
// pattern, each of the two cosines needs three multiply-accumulate passes, one
// norm product and a 17-step divide, and a cosine settled as zero or one skips
// its divide. A result waits until the output register is empty or being
// taken. The norms of stored patterns are computed when they are added.
// Configuration writes are always accepted and take effect at once.
module motion_pattern_similarity_matcher_unit #(
    parameter int TABLE_DEPTH = mpsm_pkg::MPSM_TABLE_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire mpsm_pkg::mpsm_in_t           s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output mpsm_pkg::mpsm_out_t               m_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [mpsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]                  cfg_data
);
    import mpsm_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Pattern memory.
    mpsm_entry_t mem [TABLE_DEPTH];
    mpsm_entry_t rd_reg;
    mpsm_entry_t wr_entry;
    logic        wr_en;

    mpsm_state_t state_reg, state_next;
    mpsm_in_t    in_reg, in_next;
    logic        sel_reg, sel_next;
    logic [1:0]  comp_reg, comp_next;
    logic signed [34:0] acc_reg, acc_next;
    logic signed [33:0] prod_reg, prod_next;
    logic [31:0] sqv_reg, sqv_next;
    logic [31:0] sqres_reg, sqres_next;
    logic [31:0] sqbit_reg, sqbit_next;
    logic [4:0]  iter_reg, iter_next;
    logic [15:0] na_reg, na_next;
    logic [15:0] ng_reg, ng_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [31:0] rem_reg, rem_next;
    logic [16:0] numlo_reg, numlo_next;
    logic [16:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic [15:0] ca_reg, ca_next;
    logic [15:0] cg_reg, cg_next;
    logic        match_reg, match_next;
    logic        status_reg, status_next;
    logic        m_valid_reg, m_valid_next;
    mpsm_out_t   m_data_reg, m_data_next;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0] thr_reg, thr_next;
    logic [15:0] mnorm_reg, mnorm_next;

    // Combinational helpers.
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [15:0] comp_in;
    logic signed [15:0] comp_ent;
    logic [15:0] n_in;
    logic [15:0] n_ent;
    logic [34:0] sum_sq;
    logic [32:0] sq_trial;
    logic [31:0] sq_root;
    logic [32:0] div_r;
    logic        div_ge;
    logic [32:0] div_diff;
    logic        cos_fin;
    logic [15:0] cos_val;
    logic [18:0] score_x;
    logic [18:0] thr_x5;
    logic        last_entry;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[AW-1:0]] <= wr_entry;
        end
        rd_reg <= mem[idx_reg];
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            thr_reg     <= THRESHOLD_RESET;
            mnorm_reg   <= MIN_NORM_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            thr_reg     <= thr_next;
            mnorm_reg   <= mnorm_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        sel_reg    <= sel_next;
        comp_reg   <= comp_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        sqv_reg    <= sqv_next;
        sqres_reg  <= sqres_next;
        sqbit_reg  <= sqbit_next;
        iter_reg   <= iter_next;
        na_reg     <= na_next;
        ng_reg     <= ng_next;
        idx_reg    <= idx_next;
        rem_reg    <= rem_next;
        numlo_reg  <= numlo_next;
        quo_reg    <= quo_next;
        den_reg    <= den_next;
        ca_reg     <= ca_next;
        cg_reg     <= cg_next;
        match_reg  <= match_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case ({sel_reg, comp_reg})
            {1'b0, COMP_X}: begin comp_in = in_reg.accel_x; comp_ent = rd_reg.accel_x; end
            {1'b0, COMP_Y}: begin comp_in = in_reg.accel_y; comp_ent = rd_reg.accel_y; end
            {1'b0, COMP_Z}: begin comp_in = in_reg.accel_z; comp_ent = rd_reg.accel_z; end
            {1'b1, COMP_X}: begin comp_in = in_reg.gyro_x;  comp_ent = rd_reg.gyro_x;  end
            {1'b1, COMP_Y}: begin comp_in = in_reg.gyro_y;  comp_ent = rd_reg.gyro_y;  end
            {1'b1, COMP_Z}: begin comp_in = in_reg.gyro_z;  comp_ent = rd_reg.gyro_z;  end
            default:        begin comp_in = '0;             comp_ent = '0;             end
        endcase
        n_in  = sel_reg ? ng_reg : na_reg;
        n_ent = sel_reg ? rd_reg.gyro_norm : rd_reg.accel_norm;
    end

    // Shared arithmetic terms.
    always_comb begin
        sum_sq   = 35'(acc_reg + 35'(prod_reg));
        sq_trial = {1'b0, sqres_reg} + {1'b0, sqbit_reg};
        div_r    = {rem_reg, numlo_reg[16]};
        div_ge   = (div_r >= {1'b0, den_reg});
        div_diff = div_r - {1'b0, den_reg};
        score_x  = {3'b000, ca_reg} + {2'b00, ca_reg, 1'b0} + {2'b00, cg_reg, 1'b0};
        thr_x5   = {3'b000, thr_reg} + {1'b0, thr_reg, 2'b00};
        last_entry = ((CW'(idx_reg) + CW'(1)) == count_reg);
        wr_entry = '{accel_x: in_reg.accel_x, accel_y: in_reg.accel_y,
                     accel_z: in_reg.accel_z, gyro_x: in_reg.gyro_x,
                     gyro_y: in_reg.gyro_y, gyro_z: in_reg.gyro_z,
                     accel_norm: na_reg, gyro_norm: ng_reg};
    end

    // Sequencer: next state and datapath control.
    always_comb begin
        state_next   = state_reg;
        in_next      = in_reg;
        sel_next     = sel_reg;
        comp_next    = comp_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        sqv_next     = sqv_reg;
        sqres_next   = sqres_reg;
        sqbit_next   = sqbit_reg;
        iter_next    = iter_reg;
        na_next      = na_reg;
        ng_next      = ng_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        numlo_next   = numlo_reg;
        quo_next     = quo_reg;
        den_next     = den_reg;
        ca_next      = ca_reg;
        cg_next      = cg_reg;
        match_next   = match_reg;
        status_next  = status_reg;
        m_data_next  = m_data_reg;
        count_next   = count_reg;
        thr_next     = thr_reg;
        mnorm_next   = mnorm_reg;
        m_valid_next = m_valid_reg;
        mul_a        = '0;
        mul_b        = '0;
        sq_root      = '0;
        cos_fin      = 1'b0;
        cos_val      = '0;
        wr_en        = 1'b0;

        // Configuration writes land directly.
        if (cfg_valid) begin
            if (cfg_index == CFG_MATCH_THRESHOLD) begin
                thr_next = cfg_data;
            end else if (cfg_index == CFG_MIN_NORM) begin
                mnorm_next = cfg_data;
            end
        end

        // The output register empties when its item is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next     = s_data;
                    match_next  = 1'b0;
                    status_next = 1'b0;
                    sel_next    = 1'b0;
                    comp_next   = COMP_X;
                    acc_next    = '0;
                    state_next  = ST_DONE;
                    if (s_data.req_type == REQ_CHECK) begin
                        if (count_reg != '0) begin
                            state_next = ST_SQ_MUL;
                        end
                    end else if (s_data.req_type == REQ_ADD) begin
                        if (count_reg >= CW'(TABLE_DEPTH)) begin
                            status_next = 1'b1;
                        end else begin
                            state_next = ST_SQ_MUL;
                        end
                    end else if (s_data.req_type == REQ_CLEAR) begin
                        count_next = '0;
                    end
                end
            end

            // Squares of the input vector for its norm.
            ST_SQ_MUL: begin
                mul_a      = 17'(comp_in);
                mul_b      = 17'(comp_in);
                prod_next  = 34'(mul_a) * 34'(mul_b);
                state_next = ST_SQ_ACC;
            end

            ST_SQ_ACC: begin
                acc_next = 35'(acc_reg + 35'(prod_reg));
                if (comp_reg == COMP_Z) begin
                    sqv_next   = sum_sq[31:0];
                    sqres_next = '0;
                    sqbit_next = SQRT_TOP;
                    iter_next  = '0;
                    state_next = ST_SQRT;
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_SQ_MUL;
                end
            end

            // Digit-by-digit integer square root, one result bit a cycle.
            ST_SQRT: begin
                if ({1'b0, sqv_reg} >= sq_trial) begin
                    sqv_next = sqv_reg - sq_trial[31:0];
                    sq_root  = (sqres_reg >> 1) + sqbit_reg;
                end else begin
                    sq_root  = sqres_reg >> 1;
                end
                sqres_next = sq_root;
                sqbit_next = sqbit_reg >> 2;
                iter_next  = iter_reg + 5'd1;
                if (iter_reg[3:0] == SQRT_LAST) begin
                    if (!sel_reg) begin
                        na_next    = sq_root[15:0];
                        sel_next   = 1'b1;
                        comp_next  = COMP_X;
                        acc_next   = '0;
                        state_next = ST_SQ_MUL;
                    end else begin
                        ng_next = sq_root[15:0];
                        if (in_reg.req_type == REQ_ADD) begin
                            state_next = ST_WRITE;
                        end else begin
                            idx_next   = '0;
                            state_next = ST_READ;
                        end
                    end
                end
            end

            ST_WRITE: begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = ST_DONE;
            end

            // This state waits for the registered memory read of the current entry.
            ST_READ: begin
                sel_next   = 1'b0;
                comp_next  = COMP_X;
                acc_next   = '0;
                state_next = ST_DOT_MUL;
            end

            // Dot product of input and stored vector.
            ST_DOT_MUL: begin
                mul_a      = 17'(comp_in);
                mul_b      = 17'(comp_ent);
                prod_next  = 34'(mul_a) * 34'(mul_b);
                state_next = ST_DOT_ACC;
            end

            ST_DOT_ACC: begin
                acc_next = 35'(acc_reg + 35'(prod_reg));
                if (comp_reg == COMP_Z) begin
                    state_next = ST_NPROD_MUL;
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_DOT_MUL;
                end
            end

            // Product of the two norms is the divisor.
            ST_NPROD_MUL: begin
                mul_a      = {1'b0, n_in};
                mul_b      = {1'b0, n_ent};
                prod_next  = 34'(mul_a) * 34'(mul_b);
                state_next = ST_DIV_SETUP;
            end

            // Settle the zero and clamp cases, else start the divide.
            ST_DIV_SETUP: begin
                den_next = prod_reg[31:0];
                if (n_in < mnorm_reg || n_ent < mnorm_reg || prod_reg[31:0] == '0
                        || acc_reg[34] || acc_reg == '0) begin
                    cos_fin = 1'b1;
                    cos_val = '0;
                end else if (acc_reg[33:0] >= {prod_reg[31:0], 2'b00}) begin
                    cos_fin = 1'b1;
                    cos_val = Q_ONE[15:0];
                end else begin
                    rem_next   = acc_reg[33:2];
                    numlo_next = {acc_reg[1:0], 15'd0};
                    quo_next   = '0;
                    iter_next  = '0;
                    state_next = ST_DIV;
                end
            end

            // Restoring divide, one quotient bit a cycle.
            ST_DIV: begin
                rem_next   = div_ge ? div_diff[31:0] : div_r[31:0];
                numlo_next = {numlo_reg[15:0], 1'b0};
                quo_next   = {quo_reg[15:0], div_ge};
                iter_next  = iter_reg + 5'd1;
                if (iter_reg == DIV_LAST) begin
                    cos_fin = 1'b1;
                    cos_val = ({quo_reg[15:0], div_ge} > Q_ONE) ? Q_ONE[15:0]
                                                                : {quo_reg[14:0], div_ge};
                end
            end

            // Weighted score against five times the threshold.
            ST_SCORE: begin
                if (score_x >= thr_x5) begin
                    match_next = 1'b1;
                    state_next = ST_DONE;
                end else if (last_entry) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_READ;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{is_match: match_reg,
                                     stored_count: 6'(count_reg),
                                     status: status_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A finished cosine moves on to the gyro pair or to scoring.
        if (cos_fin) begin
            if (!sel_reg) begin
                ca_next    = cos_val;
                sel_next   = 1'b1;
                comp_next  = COMP_X;
                acc_next   = '0;
                state_next = ST_DOT_MUL;
            end else begin
                cg_next    = cos_val;
                state_next = ST_SCORE;
            end
        end
    end

endmodule : motion_pattern_similarity_matcher_unit
`default_nettype wire
